### rtl/hrp_pkg.sv
// hrp_pkg: types and constants for the HTTP request parser.
// No dependencies.
package hrp_pkg;

   typedef enum logic [12:0] {
      PH_METHOD     = 13'h0001,
      PH_PATH       = 13'h0002,
      PH_VERSION    = 13'h0004,
      PH_VER_CR     = 13'h0008,
      PH_VER_LF     = 13'h0010,
      PH_LINE_START = 13'h0020,
      PH_NAME       = 13'h0040,
      PH_VALUE      = 13'h0080,
      PH_VALUE_LF   = 13'h0100,
      PH_END_LF     = 13'h0200,
      PH_BODY       = 13'h0400,
      PH_DONE       = 13'h0800,
      PH_ERROR      = 13'h1000
   } phase_type;

   localparam logic [2:0] PART_DELIM   = 3'd0;
   localparam logic [2:0] PART_METHOD  = 3'd1;
   localparam logic [2:0] PART_PATH    = 3'd2;
   localparam logic [2:0] PART_VERSION = 3'd3;
   localparam logic [2:0] PART_NAME    = 3'd4;
   localparam logic [2:0] PART_VALUE   = 3'd5;
   localparam logic [2:0] PART_BODY    = 3'd6;
   localparam logic [2:0] PART_IGNORED = 3'd7;

   localparam logic [2:0] CLOSE_NONE   = 3'd0;
   localparam logic [2:0] CLOSE_METHOD = 3'd1;
   localparam logic [2:0] CLOSE_PATH   = 3'd2;
   localparam logic [2:0] CLOSE_NAME   = 3'd3;
   localparam logic [2:0] CLOSE_VALUE  = 3'd4;
   localparam logic [2:0] CLOSE_BODY   = 3'd5;

   localparam logic [1:0] ST_BUSY  = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   localparam logic [1:0] CSR_METHOD = 2'd0;
   localparam logic [1:0] CSR_PATH   = 2'd1;
   localparam logic [1:0] CSR_NAME   = 2'd2;
   localparam logic [1:0] CSR_VALUE  = 2'd3;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SP    = 8'd32;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_ZERO  = 8'd48;

   localparam logic [12:0] LIM_CAP = 13'd4096;

   // "HTTP/1." by offset
   function automatic logic [7:0] version_char(input logic [2:0] idx);
      case (idx)
         3'd0:    version_char = 8'h48;
         3'd1:    version_char = 8'h54;
         3'd2:    version_char = 8'h54;
         3'd3:    version_char = 8'h50;
         3'd4:    version_char = 8'h2F;
         3'd5:    version_char = 8'h31;
         default: version_char = 8'h2E;
      endcase
   endfunction

   // "content-length" by offset
   function automatic logic [7:0] length_char(input logic [3:0] idx);
      case (idx)
         4'd0:    length_char = 8'h63;
         4'd1:    length_char = 8'h6F;
         4'd2:    length_char = 8'h6E;
         4'd3:    length_char = 8'h74;
         4'd4:    length_char = 8'h65;
         4'd5:    length_char = 8'h6E;
         4'd6:    length_char = 8'h74;
         4'd7:    length_char = 8'h2D;
         4'd8:    length_char = 8'h6C;
         4'd9:    length_char = 8'h65;
         4'd10:   length_char = 8'h6E;
         4'd11:   length_char = 8'h67;
         4'd12:   length_char = 8'h74;
         4'd13:   length_char = 8'h68;
         default: length_char = 8'h00;
      endcase
   endfunction

endpackage

### rtl/http_request_parser.sv
// http_request_parser: byte-serial HTTP/1.x request parser, top level.
// Depends on hrp_pkg.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_data_byte req_first_byte | in
//   rsp     | rsp_valid rsp_stall rsp_part ... rsp_status      | out
//   csr     | csr_write csr_index csr_data                     | in
//
// One word per cycle while the result is not stalled; each word is parsed
// combinationally by the phase logic and its result lands in a one-entry output register.
// Input is taken while the output register is empty or being drained.
// Reset is synchronous and restores limits and parse state.
// A stalled result holds; parse state advances only on an accepted word.
module http_request_parser #(
   parameter int unsigned MAX_REQUEST_BYTES = 8388608
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_part,
   output logic [2:0]  rsp_closed_field,
   output logic [11:0] rsp_closed_len,
   output logic [22:0] rsp_position,
   output logic        rsp_http_minor,
   output logic [31:0] rsp_content_length,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import hrp_pkg::*;

   localparam logic [22:0] LAST_POS = 23'(MAX_REQUEST_BYTES - 1);

   logic [7:0]  method_limit_ff, name_limit_ff;
   logic [12:0] path_limit_ff, value_limit_ff;
   phase_type   phase_ff, phase_in;
   logic [11:0] count_ff, count_in;
   logic [22:0] pos_ff, pos_in;
   logic        held_ff, held_in, minor_ff, minor_in, match_ff, match_in;
   logic        found_ff, found_in, digits_ff, digits_in;
   logic [31:0] blen_ff, blen_in, brem_ff, brem_in;
   logic        out_valid_ff;
   logic [2:0]  part_ff, part_in, closed_ff, closed_in;
   logic [11:0] clen_ff, clen_in;
   logic [22:0] opos_ff, opos_in;
   logic [1:0]  status_ff, status_in;
   logic        accept;

   assign req_stall = out_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         method_limit_ff <= 8'd16;
         path_limit_ff   <= 13'd2048;
         name_limit_ff   <= 8'd128;
         value_limit_ff  <= 13'd1024;
      end else if (csr_write) begin
         case (csr_index)
            CSR_METHOD: method_limit_ff <= csr_data[7:0];
            CSR_PATH:   path_limit_ff   <= csr_data;
            CSR_NAME:   name_limit_ff   <= csr_data[7:0];
            CSR_VALUE:  value_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // next-state logic for one word
   always_comb begin
      phase_type   ph;
      logic [11:0] cnt, cnt1, cnt2;
      logic        held, match, found, digits;
      logic [31:0] blen, brem;
      logic [7:0]  b, lb;
      logic [12:0] plim, vlim, lim;
      logic [22:0] pos;
      logic        nm;
      b = req_data_byte;
      lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
      if (req_first_byte) begin
         ph = PH_METHOD; cnt = '0; pos = '0; held = 1'b0; minor_in = 1'b0;
         match = 1'b1; found = 1'b0; digits = 1'b0; blen = '0; brem = '0;
      end else begin
         ph = phase_ff; cnt = count_ff; pos = pos_ff; held = held_ff;
         minor_in = minor_ff; match = match_ff; found = found_ff;
         digits = digits_ff; blen = blen_ff; brem = brem_ff;
      end
      plim = (path_limit_ff > LIM_CAP) ? LIM_CAP : path_limit_ff;
      vlim = (value_limit_ff > LIM_CAP) ? LIM_CAP : value_limit_ff;
      lim = plim;
      cnt1 = cnt + 12'd1;
      cnt2 = cnt + 12'd2;
      part_in = PART_IGNORED;
      closed_in = CLOSE_NONE;
      clen_in = '0;
      pos_in = (pos < 23'h7FFFFF) ? pos + 23'd1 : pos;
      phase_in = ph;
      count_in = cnt; held_in = held; match_in = match; found_in = found;
      digits_in = digits; blen_in = blen; brem_in = brem;
      // name handling shared by line start and name phases
      nm = 1'b0;
      case (ph)
         PH_METHOD, PH_PATH: begin
            lim = (ph == PH_METHOD) ? {5'd0, method_limit_ff} : plim;
            if (b == CH_SP) begin
               if (cnt == '0 || {1'b0, cnt} >= lim) phase_in = PH_ERROR;
               else begin
                  part_in = PART_DELIM;
                  closed_in = (ph == PH_METHOD) ? CLOSE_METHOD : CLOSE_PATH;
                  clen_in = cnt;
                  count_in = '0;
                  phase_in = (ph == PH_METHOD) ? PH_PATH : PH_VERSION;
               end
            end else begin
               part_in = (ph == PH_METHOD) ? PART_METHOD : PART_PATH;
               count_in = cnt1;
               if ({1'b0, cnt1} >= lim) phase_in = PH_ERROR;
            end
         end
         PH_VERSION: begin
            part_in = PART_VERSION;
            if (cnt < 12'd7) begin
               if (b == version_char(cnt[2:0])) count_in = cnt1;
               else phase_in = PH_ERROR;
            end else if (b == CH_ZERO || b == CH_ZERO + 8'd1) begin
               minor_in = b[0];
               count_in = '0;
               phase_in = PH_VER_CR;
            end else phase_in = PH_ERROR;
         end
         PH_VER_CR: begin
            part_in = PART_DELIM;
            phase_in = (b == CH_CR) ? PH_VER_LF : PH_ERROR;
         end
         PH_VER_LF, PH_VALUE_LF: begin
            part_in = PART_DELIM;
            phase_in = (b == CH_LF) ? PH_LINE_START : PH_ERROR;
         end
         PH_LINE_START: begin
            if (b == CH_CR) begin
               part_in = PART_DELIM;
               phase_in = PH_END_LF;
            end else begin
               cnt = '0; cnt1 = 12'd1; cnt2 = 12'd2; held = 1'b0; match = 1'b1;
               count_in = '0; held_in = 1'b0; match_in = 1'b1;
               phase_in = PH_NAME;
               nm = 1'b1;
            end
         end
         PH_NAME: nm = 1'b1;
         PH_VALUE: begin
            if (b == CH_CR) begin
               if (cnt == '0 || {1'b0, cnt} >= vlim) phase_in = PH_ERROR;
               else begin
                  part_in = PART_DELIM;
                  closed_in = CLOSE_VALUE;
                  clen_in = cnt;
                  count_in = '0;
                  digits_in = 1'b0;
                  phase_in = PH_VALUE_LF;
               end
            end else begin
               part_in = PART_VALUE;
               if (digits) begin
                  if (b >= CH_ZERO && b <= CH_ZERO + 8'd9)
                     blen_in = (blen << 3) + (blen << 1) + {24'd0, b - CH_ZERO};
                  else digits_in = 1'b0;
               end
               count_in = cnt1;
               if ({1'b0, cnt1} >= vlim) phase_in = PH_ERROR;
            end
         end
         PH_END_LF: begin
            if (b != CH_LF) phase_in = PH_ERROR;
            else begin
               part_in = PART_DELIM;
               brem_in = blen;
               if (blen == '0) begin
                  closed_in = CLOSE_BODY;
                  phase_in = PH_DONE;
               end else phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            part_in = PART_BODY;
            brem_in = brem - 32'd1;
            if (brem == 32'd1) begin
               closed_in = CLOSE_BODY;
               clen_in = (blen > 32'd4095) ? 12'd4095 : blen[11:0];
               phase_in = PH_DONE;
            end
         end
         PH_DONE: part_in = PART_IGNORED;
         default: phase_in = PH_ERROR;
      endcase
      if (nm) begin
         if (held) begin
            if (b == CH_SP) begin
               held_in = 1'b0;
               closed_in = CLOSE_NAME;
               clen_in = cnt;
               if (match && cnt == 12'd14 && !found) begin
                  found_in = 1'b1;
                  digits_in = 1'b1;
               end
               count_in = '0;
               phase_in = PH_VALUE;
               part_in = PART_DELIM;
            end else begin
               match_in = 1'b0;
               if (b == CH_COLON) begin
                  count_in = cnt1;
                  if (cnt1 >= {4'd0, name_limit_ff}) phase_in = PH_ERROR;
                  part_in = PART_DELIM;
               end else begin
                  held_in = 1'b0;
                  count_in = cnt2;
                  if (cnt2 >= {4'd0, name_limit_ff}) phase_in = PH_ERROR;
                  part_in = PART_NAME;
               end
            end
         end else if (b == CH_COLON) begin
            if (cnt < {4'd0, name_limit_ff}) held_in = 1'b1;
            else phase_in = PH_ERROR;
            part_in = PART_DELIM;
         end else begin
            if (cnt >= 12'd14 || lb != length_char(cnt[3:0])) match_in = 1'b0;
            count_in = cnt1;
            if (cnt1 >= {4'd0, name_limit_ff}) phase_in = PH_ERROR;
            part_in = PART_NAME;
         end
      end
      if (phase_in != PH_DONE && phase_in != PH_ERROR && pos >= LAST_POS)
         phase_in = PH_ERROR;
      if (phase_in == PH_ERROR) begin
         part_in = PART_IGNORED;
         closed_in = CLOSE_NONE;
         clen_in = '0;
      end
      status_in = (phase_in == PH_DONE) ? ST_DONE :
                  (phase_in == PH_ERROR) ? ST_ERROR : ST_BUSY;
      opos_in = pos;
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_METHOD; count_ff <= '0; pos_ff <= '0; held_ff <= 1'b0;
         minor_ff <= 1'b0; match_ff <= 1'b1; found_ff <= 1'b0; digits_ff <= 1'b0;
         blen_ff <= '0; brem_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in; count_ff <= count_in; pos_ff <= pos_in;
         held_ff <= held_in; minor_ff <= minor_in; match_ff <= match_in;
         found_ff <= found_in; digits_ff <= digits_in;
         blen_ff <= blen_in; brem_ff <= brem_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (accept) out_valid_ff <= 1'b1;
      else if (!rsp_stall) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         part_ff <= part_in; closed_ff <= closed_in; clen_ff <= clen_in;
         opos_ff <= opos_in; status_ff <= status_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_part           = part_ff;
   assign rsp_closed_field   = closed_ff;
   assign rsp_closed_len     = clen_ff;
   assign rsp_position       = opos_ff;
   assign rsp_http_minor     = minor_ff;
   assign rsp_content_length = blen_ff;
   assign rsp_status         = status_ff;

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for http_request_parser, built on its own parse predictor.
// Depends on hrp_pkg and the http_request_parser RTL.
// It runs a directed request table, then random requests under several limit, idle and stall settings.
module tb;
   import hrp_pkg::*;

   localparam int unsigned MAX_BYTES = 8388608;
   localparam logic [55:0] VER_TXT = "HTTP/1.";
   localparam logic [111:0] LEN_TXT = "content-length";

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       pinned;   // typed expectation present
      logic [2:0] p_part;
      logic [2:0] p_closed;
      logic [1:0] p_status;
   } word_type;

   typedef struct {
      logic [2:0]  part;
      logic [2:0]  closed;
      logic [11:0] clen;
      logic [22:0] pos;
      logic        minor;
      logic [31:0] clength;
      logic [1:0]  status;
      logic        pinned;
      logic [2:0]  p_part;
      logic [2:0]  p_closed;
      logic [1:0]  p_status;
   } parse_result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 0;
   logic        req_first_byte = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_part;
   logic [2:0]  rsp_closed_field;
   logic [11:0] rsp_closed_len;
   logic [22:0] rsp_position;
   logic        rsp_http_minor;
   logic [31:0] rsp_content_length;
   logic [1:0]  rsp_status;
   logic        csr_write = 0;
   logic [1:0]  csr_index = 0;
   logic [12:0] csr_data = 0;

   word_type         byte_feed[$];
   parse_result_type parse_expect[$];
   int               fail_count = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;
   int               hold_cycles = 0;

   // predictor state
   phase_type   ph;
   logic [11:0] fcount;
   logic [22:0] bpos;
   logic        held, minor, nmatch, lfound, dact;
   logic [31:0] blen, brem;
   int unsigned mlim, plim, nlim, vlim;

   http_request_parser u_top (.*);

   always #4 clock = ~clock;

   initial begin
      #8000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int unsigned cap4k(input int unsigned v);
      return (v > 4096) ? 4096 : v;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
   endfunction

   function automatic void clear_parse();
      ph = PH_METHOD;
      fcount = 0;
      bpos = 0;
      held = 0;
      minor = 0;
      nmatch = 1;
      lfound = 0;
      dact = 0;
      blen = 0;
      brem = 0;
   endfunction

   // header name byte, including the held colon of ": "
   function automatic void name_step(input logic [7:0] b, inout logic [2:0] part,
                                     inout logic [2:0] cl, inout logic [11:0] clen);
      if (held) begin
         if (b == CH_SP) begin
            held = 0;
            cl = CLOSE_NAME;
            clen = fcount;
            if (nmatch && fcount == 14 && !lfound) begin
               lfound = 1;
               dact = 1;
            end
            fcount = 0;
            ph = PH_VALUE;
            part = PART_DELIM;
         end else begin
            nmatch = 0;
            if (b == CH_COLON) begin
               fcount = fcount + 1;
               part = PART_DELIM;
            end else begin
               held = 0;
               fcount = fcount + 2;
               part = PART_NAME;
            end
            if (fcount >= nlim) ph = PH_ERROR;
         end
      end else if (b == CH_COLON) begin
         if (fcount < nlim) held = 1;
         else ph = PH_ERROR;
         part = PART_DELIM;
      end else begin
         if (fcount >= 14 || to_lower(b) != LEN_TXT[8*(13-fcount) +: 8]) nmatch = 0;
         fcount = fcount + 1;
         if (fcount >= nlim) ph = PH_ERROR;
         part = PART_NAME;
      end
   endfunction

   // expected result for one accepted byte
   function automatic parse_result_type parse_word(input logic [7:0] b, input logic first);
      parse_result_type r;
      logic [2:0]    part, cl;
      logic [11:0]   clen;
      logic [22:0]   pos;
      int unsigned   lim;
      if (first) clear_parse();
      pos = bpos;
      if (bpos < 23'h7FFFFF) bpos = bpos + 1;
      part = PART_IGNORED;
      cl = CLOSE_NONE;
      clen = 0;
      case (ph)
         PH_METHOD, PH_PATH: begin
            lim = (ph == PH_METHOD) ? mlim : cap4k(plim);
            if (b == CH_SP) begin
               if (fcount == 0 || fcount >= lim) ph = PH_ERROR;
               else begin
                  part = PART_DELIM;
                  cl = (ph == PH_METHOD) ? CLOSE_METHOD : CLOSE_PATH;
                  clen = fcount;
                  fcount = 0;
                  ph = (ph == PH_METHOD) ? PH_PATH : PH_VERSION;
               end
            end else begin
               part = (ph == PH_METHOD) ? PART_METHOD : PART_PATH;
               fcount = fcount + 1;
               if (fcount >= lim) ph = PH_ERROR;
            end
         end
         PH_VERSION: begin
            part = PART_VERSION;
            if (fcount < 7) begin
               if (b == VER_TXT[8*(6-fcount) +: 8]) fcount = fcount + 1;
               else ph = PH_ERROR;
            end else if (b == "0" || b == "1") begin
               minor = b[0];
               fcount = 0;
               ph = PH_VER_CR;
            end else ph = PH_ERROR;
         end
         PH_VER_CR: begin
            part = PART_DELIM;
            ph = (b == CH_CR) ? PH_VER_LF : PH_ERROR;
         end
         PH_VER_LF, PH_VALUE_LF: begin
            part = PART_DELIM;
            ph = (b == CH_LF) ? PH_LINE_START : PH_ERROR;
         end
         PH_LINE_START: begin
            if (b == CH_CR) begin
               part = PART_DELIM;
               ph = PH_END_LF;
            end else begin
               fcount = 0;
               held = 0;
               nmatch = 1;
               ph = PH_NAME;
               name_step(b, part, cl, clen);
            end
         end
         PH_NAME: name_step(b, part, cl, clen);
         PH_VALUE: begin
            lim = cap4k(vlim);
            if (b == CH_CR) begin
               if (fcount == 0 || fcount >= lim) ph = PH_ERROR;
               else begin
                  part = PART_DELIM;
                  cl = CLOSE_VALUE;
                  clen = fcount;
                  fcount = 0;
                  dact = 0;
                  ph = PH_VALUE_LF;
               end
            end else begin
               part = PART_VALUE;
               if (dact) begin
                  if (b >= "0" && b <= "9") blen = blen * 10 + (b - CH_ZERO);
                  else dact = 0;
               end
               fcount = fcount + 1;
               if (fcount >= lim) ph = PH_ERROR;
            end
         end
         PH_END_LF: begin
            if (b != CH_LF) ph = PH_ERROR;
            else begin
               part = PART_DELIM;
               brem = blen;
               if (brem == 0) begin
                  cl = CLOSE_BODY;
                  ph = PH_DONE;
               end else ph = PH_BODY;
            end
         end
         PH_BODY: begin
            part = PART_BODY;
            brem = brem - 1;
            if (brem == 0) begin
               cl = CLOSE_BODY;
               clen = (blen > 4095) ? 12'hFFF : blen[11:0];
               ph = PH_DONE;
            end
         end
         PH_DONE: part = PART_IGNORED;
         default: ph = PH_ERROR;
      endcase
      if (ph != PH_DONE && ph != PH_ERROR && pos >= MAX_BYTES - 1) ph = PH_ERROR;
      if (ph == PH_ERROR) begin
         part = PART_IGNORED;
         cl = CLOSE_NONE;
         clen = 0;
      end
      r.part = part;
      r.closed = cl;
      r.clen = clen;
      r.pos = pos;
      r.minor = minor;
      r.clength = blen;
      r.status = (ph == PH_DONE) ? ST_DONE : (ph == PH_ERROR) ? ST_ERROR : ST_BUSY;
      r.pinned = 0;
      return r;
   endfunction

   // sender: offers bytes from the feed, holds a stalled word
   always @(posedge clock) begin
      word_type         w;
      parse_result_type r;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            w = byte_feed.pop_front();
            r = parse_word(req_data_byte, req_first_byte);
            r.pinned = w.pinned;
            r.p_part = w.p_part;
            r.p_closed = w.p_closed;
            r.p_status = w.p_status;
            parse_expect.push_back(r);
         end
         // the feed front is always the next word not yet offered
         if (!req_valid || !req_stall) begin
            if (byte_feed.size() > 0 && $urandom_range(99) >= idle_pct) begin
               w = byte_feed[0];
               req_valid <= 1;
               req_data_byte <= w.data;
               req_first_byte <= w.first;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         fail_count++;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      parse_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (parse_expect.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            e = parse_expect.pop_front();
            check_field("part", e.part, rsp_part);
            check_field("closed_field", e.closed, rsp_closed_field);
            check_field("closed_len", e.clen, rsp_closed_len);
            check_field("position", e.pos, rsp_position);
            check_field("http_minor", e.minor, rsp_http_minor);
            check_field("content_length", e.clength, rsp_content_length);
            check_field("status", e.status, rsp_status);
            if (e.pinned) begin
               check_field("part", e.p_part, rsp_part);
               check_field("closed_field", e.p_closed, rsp_closed_field);
               check_field("status", e.p_status, rsp_status);
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   int items;

   task automatic put(input logic [7:0] d, input logic f);
      word_type w;
      w.data = d;
      w.first = f;
      w.pinned = 0;
      w.p_part = 0;
      w.p_closed = 0;
      w.p_status = 0;
      byte_feed.push_back(w);
      items++;
   endtask

   function automatic logic [7:0] rand_byte_except(input logic [7:0] x0, input logic [7:0] x1);
      logic [7:0] b;
      do b = $urandom_range(255); while (b == x0 || b == x1);
      return b;
   endfunction

   // short fields mostly; lengths at the limit only for small limits
   function automatic int pick_len(input int unsigned lim);
      int r;
      r = $urandom_range(99);
      if (lim < 2 || lim > 32 || r < 82) return $urandom_range(1, 6);
      if (r < 92) return lim - 1;
      if (r < 97) return lim;
      return 0;
   endfunction

   // one request, mostly well-formed, sometimes corrupted
   task automatic gen_request();
      logic [7:0]  msg[$];
      logic [31:0] decl_len;
      logic        found;
      int          n, k, h, nhdr;
      string       s;
      decl_len = 0;
      found = 0;
      if ($urandom_range(99) < 8) begin
         // plain noise
         n = $urandom_range(1, 12);
         repeat (n) msg.push_back($urandom_range(255));
      end else begin
         n = pick_len(mlim);
         repeat (n) msg.push_back(rand_byte_except(CH_SP, CH_SP));
         msg.push_back(CH_SP);
         n = pick_len(cap4k(plim));
         repeat (n) msg.push_back(rand_byte_except(CH_SP, CH_SP));
         msg.push_back(CH_SP);
         for (k = 0; k < 7; k++) msg.push_back(VER_TXT[8*(6-k) +: 8]);
         msg.push_back($urandom_range(1) ? "1" : "0");
         msg.push_back(CH_CR);
         msg.push_back(CH_LF);
         nhdr = $urandom_range(0, 4);
         for (h = 0; h < nhdr; h++) begin
            if ($urandom_range(99) < 45) begin
               // Content-Length in random case
               for (k = 0; k < 14; k++)
                  msg.push_back($urandom_range(1) && LEN_TXT[8*(13-k) +: 8] >= "a" ?
                                LEN_TXT[8*(13-k) +: 8] - 8'd32 : LEN_TXT[8*(13-k) +: 8]);
               msg.push_back(CH_COLON);
               msg.push_back(CH_SP);
               if ($urandom_range(99) < 6) s = $sformatf("%0d%0d", $urandom, $urandom_range(9));
               else s = $sformatf("%0d", $urandom_range(0, 24));
               if ($urandom_range(99) < 15) s = {s, "x7"};
               for (k = 0; k < s.len(); k++) begin
                  msg.push_back(s[k]);
               end
               if (!found) begin
                  for (k = 0; k < s.len() && s[k] >= "0" && s[k] <= "9"; k++)
                     decl_len = decl_len * 10 + (s[k] - CH_ZERO);
               end
               found = 1;
            end else begin
               n = ($urandom_range(99) < 10) ? 0 : pick_len(nlim);
               for (k = 0; k < n; k++) msg.push_back(rand_byte_except(CH_COLON, CH_CR));
               // a colon not followed by a space stays in the name
               if ($urandom_range(99) < 12) begin
                  msg.push_back(CH_COLON);
                  msg.push_back(rand_byte_except(CH_SP, CH_SP));
               end
               msg.push_back(CH_COLON);
               msg.push_back(CH_SP);
               n = pick_len(cap4k(vlim));
               repeat (n) msg.push_back(rand_byte_except(CH_CR, CH_CR));
            end
            msg.push_back(CH_CR);
            msg.push_back(CH_LF);
         end
         msg.push_back(CH_CR);
         msg.push_back(CH_LF);
         n = (decl_len > 48) ? 48 : decl_len;
         repeat (n) msg.push_back($urandom_range(255));
         if ($urandom_range(99) < 20) repeat ($urandom_range(1, 3)) msg.push_back($urandom_range(255));
         if ($urandom_range(99) < 15) msg[$urandom_range(msg.size() - 1)] = $urandom_range(255);
      end
      foreach (msg[i]) put(msg[i], i == 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [12:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_METHOD: mlim = val[7:0];
         CSR_PATH:   plim = val;
         CSR_NAME:   nlim = val[7:0];
         default:    vlim = val;
      endcase
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (byte_feed.size() != 0 || req_valid || parse_expect.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // directed table: data, first, pinned, part, closed, status
   localparam int NDIR = 19;
   word_type dir_tab[NDIR] = '{
      '{CH_SP,  1, 1, PART_IGNORED, CLOSE_NONE,   ST_ERROR},  // empty method
      '{"A",    1, 1, PART_METHOD,  CLOSE_NONE,   ST_BUSY},
      '{CH_SP,  0, 1, PART_DELIM,   CLOSE_METHOD, ST_BUSY},
      '{"/",    0, 0, 0, 0, 0},
      '{CH_SP,  0, 0, 0, 0, 0},
      '{"H",    0, 0, 0, 0, 0},
      '{"T",    0, 0, 0, 0, 0},
      '{"T",    0, 0, 0, 0, 0},
      '{"P",    0, 0, 0, 0, 0},
      '{"/",    0, 0, 0, 0, 0},
      '{"1",    0, 0, 0, 0, 0},
      '{".",    0, 0, 0, 0, 0},
      '{"0",    0, 0, 0, 0, 0},
      '{CH_CR,  0, 0, 0, 0, 0},
      '{CH_LF,  0, 0, 0, 0, 0},
      '{CH_CR,  0, 1, PART_DELIM,   CLOSE_NONE,   ST_BUSY},
      '{CH_LF,  0, 1, PART_DELIM,   CLOSE_BODY,   ST_DONE},
      '{8'hFF,  0, 1, PART_IGNORED, CLOSE_NONE,   ST_DONE},   // after completion
      '{8'h00,  1, 1, PART_METHOD,  CLOSE_NONE,   ST_BUSY}
   };

   int unsigned m_set[6] = '{16, 3, 255, 200, 1, 0};
   int unsigned p_set[6] = '{2048, 4, 8191, 4096, 1, 0};
   int unsigned n_set[6] = '{128, 15, 255, 20, 1, 0};
   int unsigned v_set[6] = '{1024, 5, 4096, 8, 1, 0};
   int          idle_set[4] = '{0, 74, 0, 13};
   int          stall_set[4] = '{0, 0, 74, 13};

   initial begin
      mlim = 16;
      plim = 2048;
      nlim = 128;
      vlim = 1024;
      clear_parse();
      repeat (11) @(posedge clock);
      reset <= 0;

      foreach (dir_tab[i]) byte_feed.push_back(dir_tab[i]);
      wait_idle();

      for (int s = 0; s < 6; s++) begin
         write_csr(CSR_METHOD, m_set[s]);
         write_csr(CSR_PATH, p_set[s]);
         write_csr(CSR_NAME, n_set[s]);
         write_csr(CSR_VALUE, v_set[s]);
         for (int m = 0; m < 4; m++) begin
            idle_pct = idle_set[m];
            stall_pct = stall_set[m];
            items = 0;
            while (items < 70) gen_request();
            // long receiver hold-off while the sender keeps offering
            if (s == 0 && m == 0) begin
               @(negedge clock);
               hold_cycles = 300;
            end
            wait_idle();
         end
      end

      idle_pct = 0;
      stall_pct = 0;
      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
